### design/arb_pkg.sv
// Shared constants and types for the alias reduction butterfly.
`default_nettype none

package arb_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int COEF_W          = 32;
  localparam int COEF_REGS       = 8;
  localparam int CIDX_W          = 3;
  localparam int FRAC_BITS       = 14;
  localparam int APB_AW          = 5;
  localparam int BAND_SIZE_DEF   = 18;
  localparam int BUTTERFLIES_DEF = 8;
  localparam int OFIFO_DEPTH     = 4;
  localparam int OF_PTR_W        = $clog2(OFIFO_DEPTH);
  localparam int OF_CNT_W        = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] a_new;
    logic [SAMPLE_W-1:0] b_new;
    logic                ovf_a;
    logic                ovf_b;
  } bfly_res_t;

  typedef struct packed {
    logic                last;
    logic                ovf;
    logic [SAMPLE_W-1:0] sample;
  } out_beat_t;

endpackage

`default_nettype wire

### design/arb_mem.sv
// Sample bank: one write port, two registered read ports.
`default_nettype none

module arb_mem
  import arb_pkg::*;
#(
  parameter int DEPTH = BAND_SIZE_DEF,
  parameter int AW    = $clog2(BAND_SIZE_DEF)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [SAMPLE_W-1:0] wdata,
  input  wire logic [AW-1:0]       raddr_a,
  input  wire logic [AW-1:0]       raddr_b,
  output logic      [SAMPLE_W-1:0] rdata_a,
  output logic      [SAMPLE_W-1:0] rdata_b
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### design/arb_cfg.sv
// APB register file holding the butterfly coefficient pairs.
`default_nettype none

module arb_cfg
  import arb_pkg::*;
(
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [APB_AW-1:0]                paddr,
  input  wire logic [COEF_W-1:0]                pwdata,
  output logic      [COEF_W-1:0]                prdata,
  output logic                                  pready,
  output logic      [COEF_REGS-1:0][COEF_W-1:0] coefs
);

  logic [CIDX_W-1:0] reg_sel;

  assign reg_sel = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign prdata  = coefs[reg_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (psel && penable && pwrite) begin
      coefs[reg_sel] <= pwdata;
    end
  end

endmodule

`default_nettype wire

### design/arb_bfly.sv
// Butterfly datapath: registered products, then sum, floor shift and range check.
`default_nettype none

module arb_bfly
  import arb_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic signed [SAMPLE_W-1:0] a,
  input  wire logic signed [SAMPLE_W-1:0] b,
  input  wire logic signed [SAMPLE_W-1:0] cs,
  input  wire logic signed [SAMPLE_W-1:0] ca,
  output bfly_res_t                       res
);

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CHK_W  = SUM_W - SAMPLE_W + 1;

  logic signed [PROD_W-1:0] p_acs, p_bca, p_bcs, p_aca;
  logic signed [SUM_W-1:0]  da, db, sa, sb;

  always_ff @(posedge clk) begin
    p_acs <= a * cs;
    p_bca <= b * ca;
    p_bcs <= b * cs;
    p_aca <= a * ca;
  end

  always_comb begin
    da = {p_acs[PROD_W-1], p_acs} - {p_bca[PROD_W-1], p_bca};
    db = {p_bcs[PROD_W-1], p_bcs} + {p_aca[PROD_W-1], p_aca};
    sa = da >>> FRAC_BITS;
    sb = db >>> FRAC_BITS;
    res.a_new = sa[SAMPLE_W-1:0];
    res.b_new = sb[SAMPLE_W-1:0];
    res.ovf_a = (sa[SUM_W-1:SAMPLE_W-1] != {CHK_W{sa[SAMPLE_W-1]}});
    res.ovf_b = (sb[SUM_W-1:SAMPLE_W-1] != {CHK_W{sb[SAMPLE_W-1]}});
  end

endmodule

`default_nettype wire

### design/arb_ofifo.sv
// Output queue that decouples the result pipeline from the downstream receiver.
`default_nettype none

module arb_ofifo
  import arb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire out_beat_t           din,
  output logic                     valid,
  input  wire logic                ready,
  output out_beat_t                dout,
  output logic      [OF_CNT_W-1:0] count
);

  out_beat_t           fifo_mem [OFIFO_DEPTH];
  logic [OF_PTR_W-1:0] wptr, rptr;
  logic                pop;

  assign valid = (count != '0);
  assign pop   = valid && ready;
  assign dout  = fifo_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + OF_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + OF_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + OF_CNT_W'(1);
        2'b01:   count <= count - OF_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/alias_reduction_butterfly.sv
// Alias reduction butterfly top level: control, bank pipeline and flush sequencer.
//
// Samples enter on the s_* stream (s_tdata = sample, s_tlast = last sample of the
// granule), BAND_SIZE per subband. Results leave on the m_* stream one subband
// behind: m_tdata = sample, m_tlast = final result of the granule, m_tuser =
// overflow. Coefficient pairs are written over the APB port; the user must write
// them only while the block idles; the block does not enforce it. One sample is
// accepted per cycle. The subband store is two ping-pong banks, each with one
// write and two read ports; the butterfly runs as read, multiply, then sum and
// write back, with forwarding of in-flight writes. After a granule end the input
// is held off while the remaining held samples drain, one read per cycle while
// credit lasts. A four-entry output queue absorbs receiver stalls; the input is
// throttled by credit so no beat is ever dropped. Reset clears the position, the
// previous-subband flag, the overflow marks, the queue and the coefficients; bank
// contents are not cleared and are never read before written.
`default_nettype none

module alias_reduction_butterfly
  import arb_pkg::*;
#(
  parameter int BAND_SIZE   = BAND_SIZE_DEF,
  parameter int BUTTERFLIES = BUTTERFLIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
  output logic                     m_tlast,
  output logic                     m_tuser,   // [0] overflow
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [COEF_W-1:0]   pwdata,
  output logic      [COEF_W-1:0]   prdata,
  output logic                     pready
);

  localparam int IDX_W = $clog2(BAND_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BAND_SIZE - 1);
  localparam logic [IDX_W-1:0] NUM_BFLY = IDX_W'(BUTTERFLIES);

  typedef enum logic [2:0] {
    FL_IDLE = 3'b001,
    FL_PREV = 3'b010,
    FL_CUR  = 3'b100
  } fl_state_t;

  typedef struct packed {
    logic                emit;
    logic                last;
    logic                wr;
    logic                bfly;
    logic                cbank;
    logic [IDX_W-1:0]    caddr;
    logic [IDX_W-1:0]    paddr;
    logic                ebank;
    logic [IDX_W-1:0]    eaddr;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  logic [COEF_REGS-1:0][COEF_W-1:0] coefs;

  logic [IDX_W-1:0] idx;
  logic             have_prev;
  logic             cur_bank;
  fl_state_t        fl_state;
  logic [IDX_W-1:0] fl_addr;
  logic [IDX_W-1:0] fl_end;

  logic [OF_CNT_W-1:0] ofifo_count;
  logic [OF_CNT_W:0]   infl;
  logic                can_issue, acc, fl_issue;

  item_t             s0, s1, s2;
  logic              s1_valid, s2_valid;
  logic [COEF_W-1:0] s1_coef;

  logic [SAMPLE_W-1:0] rda0, rdb0, rda1, rdb1;
  logic                w0_en, w1_en;
  logic [IDX_W-1:0]    w0_addr, w1_addr;
  logic [SAMPLE_W-1:0] w0_data, w1_data;

  bfly_res_t           bres;
  logic                cur_we, prv_we;
  logic [SAMPLE_W-1:0] cur_wd, prv_wd;

  logic                lwc_v, lwc_bank, lwp_v, lwp_bank;
  logic [IDX_W-1:0]    lwc_addr, lwp_addr;
  logic [SAMPLE_W-1:0] lwc_data, lwp_data;

  logic                s1_pbank;
  logic [SAMPLE_W-1:0] a_fwd, e_fwd, s2_edata, edata;
  logic                own_hit, emark;

  logic [1:0][BAND_SIZE-1:0] marks;

  out_beat_t push_beat, pop_beat;

  arb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  assign infl = (OF_CNT_W+1)'(ofifo_count) + (OF_CNT_W+1)'(s1_valid)
              + (OF_CNT_W+1)'(s2_valid);
  assign can_issue = (infl < (OF_CNT_W+1)'(OFIFO_DEPTH));
  assign s_tready  = (fl_state == FL_IDLE) && can_issue;
  assign acc       = s_tvalid && s_tready;
  assign fl_issue  = (fl_state != FL_IDLE) && can_issue;

  always_comb begin
    if (fl_state == FL_IDLE) begin
      s0.emit   = have_prev;
      s0.last   = 1'b0;
      s0.wr     = 1'b1;
      s0.bfly   = have_prev && (idx < NUM_BFLY);
      s0.cbank  = cur_bank;
      s0.caddr  = idx;
      s0.paddr  = LAST_IDX - idx;
      s0.ebank  = ~cur_bank;
      s0.eaddr  = idx;
      s0.sample = s_tdata;
    end else begin
      s0.emit   = 1'b1;
      s0.last   = (fl_state == FL_CUR) && (fl_addr == fl_end);
      s0.wr     = 1'b0;
      s0.bfly   = 1'b0;
      s0.cbank  = cur_bank;
      s0.caddr  = fl_addr;
      s0.paddr  = fl_addr;
      s0.ebank  = (fl_state == FL_PREV) ? ~cur_bank : cur_bank;
      s0.eaddr  = fl_addr;
      s0.sample = '0;
    end
  end

  // position, bank and flush sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      have_prev <= 1'b0;
      cur_bank  <= 1'b0;
      fl_state  <= FL_IDLE;
      fl_addr   <= '0;
      fl_end    <= '0;
    end else begin
      if (acc) begin
        if (s_tlast) begin
          idx       <= '0;
          have_prev <= 1'b0;
          fl_end    <= idx;
          if (have_prev && (idx != LAST_IDX)) begin
            fl_state <= FL_PREV;
            fl_addr  <= idx + IDX_W'(1);
          end else begin
            fl_state <= FL_CUR;
            fl_addr  <= '0;
          end
        end else if (idx == LAST_IDX) begin
          idx       <= '0;
          have_prev <= 1'b1;
          cur_bank  <= ~cur_bank;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (fl_issue) begin
        case (fl_state)
          FL_PREV: begin
            if (fl_addr == LAST_IDX) begin
              fl_state <= FL_CUR;
              fl_addr  <= '0;
            end else begin
              fl_addr <= fl_addr + IDX_W'(1);
            end
          end
          FL_CUR: begin
            if (fl_addr == fl_end) begin
              fl_state <= FL_IDLE;
            end else begin
              fl_addr <= fl_addr + IDX_W'(1);
            end
          end
          default: fl_state <= FL_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      lwc_v    <= 1'b0;
      lwp_v    <= 1'b0;
    end else begin
      s1_valid <= acc || fl_issue;
      s2_valid <= s1_valid;
      lwc_v    <= cur_we;
      lwp_v    <= prv_we;
    end
  end

  always_ff @(posedge clk) begin
    s1       <= s0;
    s1_coef  <= coefs[s0.caddr[CIDX_W-1:0]];
    s2       <= s1;
    s2_edata <= e_fwd;
    lwc_bank <= s2.cbank;
    lwc_addr <= s2.caddr;
    lwc_data <= cur_wd;
    lwp_bank <= ~s2.cbank;
    lwp_addr <= s2.paddr;
    lwp_data <= prv_wd;
  end

  arb_mem #(.DEPTH(BAND_SIZE), .AW(IDX_W)) u_bank0 (
    .clk     (clk),
    .we      (w0_en),
    .waddr   (w0_addr),
    .wdata   (w0_data),
    .raddr_a (s0.paddr),
    .raddr_b (s0.eaddr),
    .rdata_a (rda0),
    .rdata_b (rdb0)
  );

  arb_mem #(.DEPTH(BAND_SIZE), .AW(IDX_W)) u_bank1 (
    .clk     (clk),
    .we      (w1_en),
    .waddr   (w1_addr),
    .wdata   (w1_data),
    .raddr_a (s0.paddr),
    .raddr_b (s0.eaddr),
    .rdata_a (rda1),
    .rdata_b (rdb1)
  );

  // forward in-flight writes into the operand and emitted sample
  always_comb begin
    s1_pbank = ~s1.cbank;
    a_fwd    = s1.cbank ? rda0 : rda1;
    if (lwc_v && (lwc_bank == s1_pbank) && (lwc_addr == s1.paddr)) begin
      a_fwd = lwc_data;
    end
    if (lwp_v && (lwp_bank == s1_pbank) && (lwp_addr == s1.paddr)) begin
      a_fwd = lwp_data;
    end
    if (cur_we && !s2.bfly && (s2.cbank == s1_pbank) && (s2.caddr == s1.paddr)) begin
      a_fwd = s2.sample;
    end

    e_fwd = s1.ebank ? rdb1 : rdb0;
    if (lwc_v && (lwc_bank == s1.ebank) && (lwc_addr == s1.eaddr)) begin
      e_fwd = lwc_data;
    end
    if (lwp_v && (lwp_bank == s1.ebank) && (lwp_addr == s1.eaddr)) begin
      e_fwd = lwp_data;
    end
    if (cur_we && (s2.cbank == s1.ebank) && (s2.caddr == s1.eaddr)) begin
      e_fwd = cur_wd;
    end
    if (prv_we && (~s2.cbank == s1.ebank) && (s2.paddr == s1.eaddr)) begin
      e_fwd = prv_wd;
    end
  end

  arb_bfly u_bfly (
    .clk (clk),
    .a   (a_fwd),
    .b   (s1.sample),
    .cs  (s1_coef[COEF_W-1:SAMPLE_W]),
    .ca  (s1_coef[SAMPLE_W-1:0]),
    .res (bres)
  );

  assign cur_we = s2_valid && s2.wr;
  assign prv_we = s2_valid && s2.bfly;
  assign cur_wd = s2.bfly ? bres.b_new : s2.sample;
  assign prv_wd = bres.a_new;

  always_comb begin
    w0_en   = 1'b0;
    w0_addr = s2.caddr;
    w0_data = cur_wd;
    w1_en   = 1'b0;
    w1_addr = s2.caddr;
    w1_data = cur_wd;
    if (cur_we) begin
      if (s2.cbank) begin
        w1_en = 1'b1;
      end else begin
        w0_en = 1'b1;
      end
    end
    if (prv_we) begin
      if (s2.cbank) begin
        w0_en   = 1'b1;
        w0_addr = s2.paddr;
        w0_data = prv_wd;
      end else begin
        w1_en   = 1'b1;
        w1_addr = s2.paddr;
        w1_data = prv_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
    end else begin
      if (cur_we) begin
        marks[s2.cbank][s2.caddr] <= s2.bfly && bres.ovf_b;
      end
      if (prv_we) begin
        marks[~s2.cbank][s2.paddr] <= marks[~s2.cbank][s2.paddr] | bres.ovf_a;
      end
    end
  end

  assign own_hit = prv_we && (~s2.cbank == s2.ebank) && (s2.paddr == s2.eaddr);
  assign edata   = own_hit ? bres.a_new : s2_edata;
  assign emark   = marks[s2.ebank][s2.eaddr] | (own_hit && bres.ovf_a);

  assign push_beat = '{last: s2.last, ovf: emark, sample: edata};

  arb_ofifo u_ofifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_valid && s2.emit),
    .din   (push_beat),
    .valid (m_tvalid),
    .ready (m_tready),
    .dout  (pop_beat),
    .count (ofifo_count)
  );

  assign m_tdata = pop_beat.sample;
  assign m_tlast = pop_beat.last;
  assign m_tuser = pop_beat.ovf;

  a_no_queue_overrun: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2.emit) |-> (ofifo_count != OF_CNT_W'(OFIFO_DEPTH)))
    else $error("result pushed into a full output queue");

  a_flush_follows_end: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tlast) |=> (fl_state != FL_IDLE))
    else $error("granule end not followed by a flush");

  a_prev_at_band_start: assert property (@(posedge clk) disable iff (rst)
    $rose(have_prev) |-> (idx == '0))
    else $error("previous subband marked held away from a band start");

  a_no_product_hazard: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.bfly && s2_valid && s2.bfly) |->
      !((s2.cbank != s1.cbank) && (s2.caddr == s1.paddr)) &&
      !((s2.cbank == s1.cbank) && (s2.paddr == s1.paddr)))
    else $error("butterfly operand depends on an unfinished butterfly");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the alias reduction butterfly stream block.
`timescale 1ns / 100ps

module tb_top;
  import arb_pkg::*;

  localparam int BAND        = BAND_SIZE_DEF;
  localparam int BFLY        = BUTTERFLIES_DEF;
  localparam int SETTLE      = 2 * BAND + 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [APB_AW-1:0]   paddr    = '0;
  logic [COEF_W-1:0]   pwdata   = '0;
  logic [COEF_W-1:0]   prdata;
  logic                pready;

  alias_reduction_butterfly u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Predictor state
  logic [COEF_W-1:0]   coef_shadow [COEF_REGS];
  logic [SAMPLE_W-1:0] prev_band   [BAND];
  logic [SAMPLE_W-1:0] cur_band    [BAND];
  bit                  prev_mark   [BAND];
  bit                  cur_mark    [BAND];
  int                  band_pos    = 0;
  bit                  prev_valid  = 1'b0;
  out_beat_t           pending_beats[$];

  int       mismatch_count = 0;
  int       checked_beats  = 0;
  int       cycle_count    = 0;
  int       burst_left     = 0;
  bit       steady_send    = 1'b0;
  int       hold_request   = 0;
  int       hold_left      = 0;
  int       mode_left      = 0;
  rx_mode_t rx_mode        = RX_OPEN;

  initial begin
    for (int i = 0; i < COEF_REGS; i++) coef_shadow[i] = '0;
    for (int i = 0; i < BAND; i++) begin
      prev_band[i] = '0;
      cur_band[i]  = '0;
      prev_mark[i] = 1'b0;
      cur_mark[i]  = 1'b0;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic logic [16:0] scale_q14(input longint acc);
    longint r;
    r = acc >>> FRAC_BITS;
    return {(r < -32768 || r > 32767), r[15:0]};
  endfunction

  task automatic push_beat(input logic [SAMPLE_W-1:0] s, input bit ovf, input bit last);
    out_beat_t b;
    b.sample = s;
    b.ovf    = ovf;
    b.last   = last;
    pending_beats.push_back(b);
  endtask

  task automatic predict_alias_sample(input logic [SAMPLE_W-1:0] d, input bit granule_end);
    int          idx;
    int          p;
    logic [31:0] c;
    longint      a, b, cs, ca;
    logic [16:0] ra, rb;
    idx = band_pos;
    if (idx >= BAND) idx = 0;
    cur_band[idx] = d;
    cur_mark[idx] = 1'b0;
    if (prev_valid) begin
      if (idx < BFLY) begin
        p  = BAND - 1 - idx;
        c  = coef_shadow[idx % COEF_REGS];
        a  = longint'($signed(prev_band[p]));
        b  = longint'($signed(cur_band[idx]));
        cs = longint'($signed(c[31:16]));
        ca = longint'($signed(c[15:0]));
        ra = scale_q14(a * cs - b * ca);
        rb = scale_q14(b * cs + a * ca);
        prev_band[p]  = ra[15:0];
        prev_mark[p]  = prev_mark[p] | ra[16];
        cur_band[idx] = rb[15:0];
        cur_mark[idx] = cur_mark[idx] | rb[16];
      end
      push_beat(prev_band[idx], prev_mark[idx], 1'b0);
    end
    if (granule_end) begin
      if (prev_valid)
        for (int k = idx + 1; k < BAND; k++) push_beat(prev_band[k], prev_mark[k], 1'b0);
      for (int k = 0; k <= idx; k++) push_beat(cur_band[k], cur_mark[k], k == idx);
      band_pos   = 0;
      prev_valid = 1'b0;
      for (int k = 0; k < BAND; k++) begin
        prev_mark[k] = 1'b0;
        cur_mark[k]  = 1'b0;
      end
    end else begin
      idx++;
      if (idx >= BAND) begin
        for (int k = 0; k < BAND; k++) begin
          prev_band[k] = cur_band[k];
          prev_mark[k] = cur_mark[k];
          cur_mark[k]  = 1'b0;
        end
        prev_valid = 1'b1;
        idx = 0;
      end
      band_pos = idx;
    end
  endtask

  // APB access: setup cycle, then access cycle until pready
  task automatic apb_access(input bit wr, input int idx, input logic [COEF_W-1:0] wdata,
                            output logic [COEF_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_coef(input int idx);
    logic [COEF_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== coef_shadow[idx])
      note_mismatch($sformatf("coef_pair_%0d read %h, want %h", idx, rd, coef_shadow[idx]));
  endtask

  task automatic write_coef(input int idx, input logic [COEF_W-1:0] value);
    logic [COEF_W-1:0] rd;
    apb_access(1'b1, idx, value, rd);
    coef_shadow[idx] = value;
    check_coef(idx);
  endtask

  // Offer one beat, with burst gaps unless steady_send is set
  task automatic send_sample(input logic [SAMPLE_W-1:0] d, input bit granule_end);
    int gap;
    if (!steady_send && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= granule_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_alias_sample(d, granule_end);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 7) == 0)
      case ($urandom_range(0, 3))
        0: v = 16'h8000;
        1: v = 16'h7FFF;
        2: v = 16'h0000;
        default: v = 16'hFFFF;
      endcase
    return v;
  endfunction

  task automatic send_granule(input int len, inout int sent);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
    sent += len;
  endtask

  // Zero coefficients after reset; one-beat granule
  task automatic test_single_sample();
    for (int i = 0; i < COEF_REGS; i++) check_coef(i);
    send_sample(16'h8000, 1'b1);
    wait_idle();
  endtask

  // Extreme coefficients and samples, granule ending early in its second subband
  task automatic test_extremes();
    logic [SAMPLE_W-1:0] vals [4];
    vals[0] = 16'h8000;
    vals[1] = 16'h7FFF;
    vals[2] = 16'h0000;
    vals[3] = 16'hFFFF;
    for (int i = 0; i < COEF_REGS; i++)
      case (i % 4)
        0: write_coef(i, 32'h8000_8000);
        1: write_coef(i, 32'h7FFF_7FFF);
        2: write_coef(i, 32'hFFFF_FFFF);
        default: write_coef(i, 32'h4000_8000);
      endcase
    for (int i = 0; i < BAND; i++) send_sample(vals[i % 4], 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_random();
    int          sent;
    int          len;
    int          r;
    logic [15:0] cs16, ca16;
    logic [31:0] pick;
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < COEF_REGS; i++) begin
        case (phase)
          0: pick = $urandom;
          1: begin
            case ($urandom_range(0, 5))
              0: pick = 32'h8000_8000;
              1: pick = 32'h7FFF_7FFF;
              2: pick = 32'hFFFF_FFFF;
              3: pick = 32'h0000_7FFF;
              4: pick = 32'h8000_0000;
              default: pick = $urandom;
            endcase
          end
          default: begin
            cs16 = 16'($urandom_range(8000, 16384));
            ca16 = 16'(-$signed(17'($urandom_range(0, 8000))));
            pick = {cs16, ca16};
          end
        endcase
        write_coef(i, pick);
      end
      steady_send = (phase == 1);
      while (sent < 14 * (phase + 1)) begin
        r = $urandom_range(0, 9);
        if (r < 2) len = $urandom_range(1, BAND - 1);
        else if (r == 2) len = BAND * $urandom_range(1, 2);
        else len = $urandom_range(BAND + 1, 2 * BAND + 4);
        send_granule(len, sent);
      end
      steady_send = 1'b0;
      wait_idle();
    end
  endtask

  // Sender pauses mid-granule, then the receiver holds off while input keeps coming
  task automatic test_backpressure();
    steady_send = 1'b1;
    for (int i = 0; i < 2 * BAND; i++) begin
      if (i == BAND + 2) wait_results();
      if (i == BAND + 3) hold_request = 300;
      send_sample(pick_sample(), i == 2 * BAND - 1);
    end
    steady_send = 1'b0;
    wait_idle();
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= (mode_left % 5 != 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin : beat_check
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat sample %h last %b ovf %b",
                                m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending_beats.pop_front();
        if (m_tdata !== want.sample || m_tlast !== want.last || m_tuser !== want.ovf)
          note_mismatch($sformatf("beat %0d: sample %h want %h, last %b want %b, ovf %b want %b",
                                  checked_beats, m_tdata, want.sample, m_tlast, want.last,
                                  m_tuser, want.ovf));
      end
      checked_beats++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_sample();
    test_extremes();
    test_random();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
